### rtl/dtk_pkg.sv
// dtk_pkg: shared types and constants of the differential drive pd tracker
// item structs, command and register codes, sequencer states, divider request/response
// no dependencies
package dtk_pkg;

    // finishing speed boost added to base speed when one wheel is done
    localparam logic [15:0] FINISH_BOOST = 16'd10;

    // divider datapath width and step counter width
    localparam int DIV_W   = 32;
    localparam int DIV_CW  = $clog2(DIV_W);
    localparam int QUO_W   = 16;

    // configuration write port
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 16;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_POLL  = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_AW-1:0] {
        REG_LEFT_DIR     = 3'd0,
        REG_RIGHT_DIR    = 3'd1,
        REG_LEFT_AMOUNT  = 3'd2,
        REG_RIGHT_AMOUNT = 3'd3,
        REG_BASE_SPEED   = 3'd4,
        REG_PROP_GAIN    = 3'd5,
        REG_DERIV_GAIN   = 3'd6,
        REG_POLL_PERIOD  = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic        [1:0]  command;
        logic signed [15:0] left_position;
        logic signed [15:0] right_position;
        logic signed [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] left_drive;
        logic signed [15:0] right_drive;
        logic               drive_update;
        logic               moving;
    } t_out_item;

    typedef struct packed {
        logic signed [1:0]  left_dir;
        logic signed [1:0]  right_dir;
        logic        [14:0] left_amount;
        logic        [14:0] right_amount;
        logic        [14:0] base_speed;
        logic        [7:0]  prop_gain;
        logic        [7:0]  deriv_gain;
        logic        [15:0] poll_period;
    } t_cfg;

    typedef struct packed {
        logic                    start;
        logic signed [DIV_W-1:0] num;
        logic signed [DIV_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                    done;
        logic signed [QUO_W-1:0] quo;
    } t_div_rsp;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_ABS,
        DIV_ITER,
        DIV_SIGN
    } t_div_state;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EVAL,
        S_NUM,
        S_WAIT1,
        S_ERR,
        S_PD,
        S_DEN,
        S_GO2,
        S_WAIT2,
        S_MIX,
        S_DRV,
        S_OUT
    } t_seq_state;

endpackage

### rtl/dtk_cfg.sv
// dtk_cfg: configuration register file of the tracker
// decodes the plain write port into the register struct; uses dtk_pkg
module dtk_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [dtk_pkg::CFG_AW-1:0]   i_cfg_idx,
    input  logic [dtk_pkg::CFG_DW-1:0]   i_cfg_data,
    output dtk_pkg::t_cfg                o_cfg
);

    dtk_pkg::t_cfg r_cfg;

    // register writes, reset to the documented defaults
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.left_dir     <= 2'sd1;
            r_cfg.right_dir    <= 2'sd1;
            r_cfg.left_amount  <= 15'd1;
            r_cfg.right_amount <= 15'd0;
            r_cfg.base_speed   <= 15'd0;
            r_cfg.prop_gain    <= 8'd1;
            r_cfg.deriv_gain   <= 8'd0;
            r_cfg.poll_period  <= 16'd10;
        end else if (i_cfg_we) begin
            unique case (dtk_pkg::t_cfg_idx'(i_cfg_idx))
                dtk_pkg::REG_LEFT_DIR:     r_cfg.left_dir     <= i_cfg_data[1:0];
                dtk_pkg::REG_RIGHT_DIR:    r_cfg.right_dir    <= i_cfg_data[1:0];
                dtk_pkg::REG_LEFT_AMOUNT:  r_cfg.left_amount  <= i_cfg_data[14:0];
                dtk_pkg::REG_RIGHT_AMOUNT: r_cfg.right_amount <= i_cfg_data[14:0];
                dtk_pkg::REG_BASE_SPEED:   r_cfg.base_speed   <= i_cfg_data[14:0];
                dtk_pkg::REG_PROP_GAIN:    r_cfg.prop_gain    <= i_cfg_data[7:0];
                dtk_pkg::REG_DERIV_GAIN:   r_cfg.deriv_gain   <= i_cfg_data[7:0];
                dtk_pkg::REG_POLL_PERIOD:  r_cfg.poll_period  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/dtk_div.sv
// dtk_div: shared iterative signed divider, one quotient bit per cycle
// truncating division, zero divisor gives zero; returns the low quotient bits; uses dtk_pkg
module dtk_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  dtk_pkg::t_div_req i_req,
    output dtk_pkg::t_div_rsp o_rsp
);

    localparam int W  = dtk_pkg::DIV_W;
    localparam int CW = dtk_pkg::DIV_CW;
    localparam int QW = dtk_pkg::QUO_W;

    dtk_pkg::t_div_state r_state, n_state;
    logic                r_done, n_done;
    logic [W-1:0]        r_num, n_num;
    logic [W-1:0]        r_den, n_den;
    logic [W-1:0]        r_rem, n_rem;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_neg, n_neg;
    logic                r_zero, n_zero;
    logic [QW-1:0]       r_quo, n_quo;

    logic [W:0]          s_trial;
    logic [W:0]          s_diff;
    logic [W-1:0]        s_quo_full;

    // restoring step and sign fix-up
    always_comb begin
        s_trial    = {r_rem, r_num[W-1]};
        s_diff     = s_trial - {1'b0, r_den};
        s_quo_full = r_neg ? (~r_num + 1'b1) : r_num;
    end

    // sequencer of the shared unit
    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_num   = r_num;
        n_den   = r_den;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_zero  = r_zero;
        n_quo   = r_quo;
        unique case (r_state)
            dtk_pkg::DIV_IDLE: begin
                if (i_req.start) begin
                    n_num   = i_req.num;
                    n_den   = i_req.den;
                    n_state = dtk_pkg::DIV_ABS;
                end
            end
            dtk_pkg::DIV_ABS: begin
                n_neg   = r_num[W-1] ^ r_den[W-1];
                n_zero  = (r_den == '0);
                n_num   = r_num[W-1] ? (~r_num + 1'b1) : r_num;
                n_den   = r_den[W-1] ? (~r_den + 1'b1) : r_den;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = dtk_pkg::DIV_ITER;
            end
            dtk_pkg::DIV_ITER: begin
                if (!s_diff[W]) begin
                    n_rem = s_diff[W-1:0];
                    n_num = {r_num[W-2:0], 1'b1};
                end else begin
                    n_rem = s_trial[W-1:0];
                    n_num = {r_num[W-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    n_state = dtk_pkg::DIV_SIGN;
                end
            end
            dtk_pkg::DIV_SIGN: begin
                n_quo   = r_zero ? '0 : s_quo_full[QW-1:0];
                n_done  = 1'b1;
                n_state = dtk_pkg::DIV_IDLE;
            end
            default: n_state = dtk_pkg::DIV_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtk_pkg::DIV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_num  <= n_num;
        r_den  <= n_den;
        r_rem  <= n_rem;
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_zero <= n_zero;
        r_quo  <= n_quo;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    // a start only arrives while the unit is free
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == dtk_pkg::DIV_IDLE)
        else $error("divider started while busy");

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dtk_pkg::DIV_ITER) && !r_zero |-> r_rem < r_den)
        else $error("divider remainder out of range");

    // done is a single pulse that returns the unit to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_state == dtk_pkg::DIV_IDLE)
        else $error("divider done while not idle");

endmodule

### rtl/differential_drive_pd_tracker_core.sv
// differential_drive_pd_tracker_core: top level of the pd distance-ratio tracker
// sequencer and datapath around dtk_cfg and the shared divider dtk_div; uses dtk_pkg
//
// Usage:
//   Input channel i_in_item / i_in_valid / o_in_stall carries one command item
//   (start, poll, stop) with both encoder positions and the time in ms.
//   Output channel o_out_item / o_out_valid / i_out_stall returns exactly one
//   result item per input item: both drives, drive_update and moving.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
//   Start, stop, idle or early polls and finishing polls go from S_EVAL straight
//   to S_OUT with their result. A poll that runs the pd update makes two
//   passes through the shared one-bit-per-cycle divider (the distance ratio,
//   then the derivative) before S_DRV writes its result to the output register.
//   One item is in the block at a time; o_in_stall stays high from acceptance
//   until the result item is taken, so the next item enters the cycle after.
//   When the receiver stalls, the result item is held unchanged in the output
//   register. Reset (synchronous, active low) clears the move state and
//   restores the register defaults; the block is ready the cycle after.
module differential_drive_pd_tracker_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  dtk_pkg::t_in_item            i_in_item,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    output dtk_pkg::t_out_item           o_out_item,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    input  logic                         i_cfg_we,
    input  logic [dtk_pkg::CFG_AW-1:0]   i_cfg_idx,
    input  logic [dtk_pkg::CFG_DW-1:0]   i_cfg_data
);

    dtk_pkg::t_cfg      s_cfg;
    dtk_pkg::t_div_req  s_div_req;
    dtk_pkg::t_div_rsp  s_div_rsp;

    dtk_pkg::t_seq_state r_state, n_state;

    // move state
    logic               r_active, n_active;
    logic [31:0]        r_last_time, n_last_time;
    logic signed [15:0] r_last_err, n_last_err;
    logic [15:0]        r_rep, n_rep;
    logic signed [15:0] r_lo, n_lo;
    logic signed [15:0] r_ro, n_ro;

    // work registers
    dtk_pkg::t_in_item  r_item, n_item;
    logic [31:0]        r_dt, n_dt;
    logic signed [31:0] r_prod, n_prod;
    logic signed [15:0] r_err, n_err;
    logic signed [15:0] r_p, n_p;
    logic signed [24:0] r_n2, n_n2;
    logic [31:0]        r_den, n_den;
    logic signed [15:0] r_g, n_g;
    dtk_pkg::t_out_item r_out, n_out;

    // combinational helpers
    logic               s_accept;
    logic               s_early;
    logic               s_ldone;
    logic               s_rdone;
    logic signed [16:0] s_ldiff;
    logic signed [32:0] s_prod_full;
    logic signed [16:0] s_boost;
    logic signed [24:0] s_p_full;
    logic signed [16:0] s_ediff;
    logic signed [25:0] s_n2_full;
    logic [47:0]        s_den_full;
    logic signed [15:0] s_half_kp;
    logic signed [17:0] s_lmag;
    logic signed [17:0] s_rmag;

    // signed direction times magnitude, wrapped to 16 bits
    function automatic logic signed [15:0] dir_mul(input logic signed [1:0] dir,
                                                   input logic signed [17:0] mag);
        logic signed [19:0] prod;
        prod = dir * mag;
        return prod[15:0];
    endfunction

    dtk_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (s_cfg)
    );

    dtk_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_div_req),
        .o_rsp   (s_div_rsp)
    );

    assign s_accept = i_in_valid && !o_in_stall;

    // datapath terms
    always_comb begin
        s_early     = $signed(r_item.now_ms - $signed(r_last_time))
                      < $signed({16'd0, s_cfg.poll_period});
        s_ldone     = $signed({{2{r_item.left_position[15]}}, r_item.left_position})
                      >= ($signed({{2{r_lo[15]}}, r_lo}) + $signed({3'd0, s_cfg.left_amount}));
        s_rdone     = $signed({{2{r_item.right_position[15]}}, r_item.right_position})
                      >= ($signed({{2{r_ro[15]}}, r_ro}) + $signed({3'd0, s_cfg.right_amount}));
        s_ldiff     = $signed({r_item.left_position[15], r_item.left_position})
                      - $signed({r_lo[15], r_lo});
        s_prod_full = s_ldiff * $signed({1'b0, s_cfg.right_amount});
        s_boost     = $signed({2'd0, s_cfg.base_speed} + {1'b0, dtk_pkg::FINISH_BOOST});
        s_p_full    = $signed({1'b0, s_cfg.prop_gain}) * r_err;
        s_ediff     = $signed({r_err[15], r_err}) - $signed({r_last_err[15], r_last_err});
        s_n2_full   = $signed({1'b0, s_cfg.deriv_gain}) * s_ediff;
        s_den_full  = r_dt * r_rep;
        s_half_kp   = $signed({9'd0, s_cfg.prop_gain[7:1]});
        s_lmag      = r_g[15] ? ($signed({3'd0, s_cfg.base_speed}) - $signed({{2{r_g[15]}}, r_g}))
                              : $signed({3'd0, s_cfg.base_speed});
        s_rmag      = (!r_g[15] && (r_g != '0))
                      ? ($signed({3'd0, s_cfg.base_speed}) + $signed({2'd0, r_g}))
                      : $signed({3'd0, s_cfg.base_speed});
    end

    // divider requests: distance ratio first, derivative second
    always_comb begin
        s_div_req.start = (r_state == dtk_pkg::S_NUM) || (r_state == dtk_pkg::S_GO2);
        if (r_state == dtk_pkg::S_NUM) begin
            s_div_req.num = r_prod + $signed({18'd0, s_cfg.left_amount[14:1]});
            s_div_req.den = $signed({17'd0, s_cfg.left_amount});
        end else begin
            s_div_req.num = $signed({{7{r_n2[24]}}, r_n2});
            s_div_req.den = $signed(r_den);
        end
    end

    // sequencer next state and register updates
    always_comb begin
        n_state     = r_state;
        n_active    = r_active;
        n_last_time = r_last_time;
        n_last_err  = r_last_err;
        n_rep       = r_rep;
        n_lo        = r_lo;
        n_ro        = r_ro;
        n_item      = r_item;
        n_dt        = r_dt;
        n_prod      = r_prod;
        n_err       = r_err;
        n_p         = r_p;
        n_n2        = r_n2;
        n_den       = r_den;
        n_g         = r_g;
        n_out       = r_out;
        unique case (r_state)
            dtk_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_item  = i_in_item;
                    n_state = dtk_pkg::S_EVAL;
                end
            end
            dtk_pkg::S_EVAL: begin
                n_out   = '0;
                n_dt    = r_item.now_ms - r_last_time;
                n_prod  = s_prod_full[31:0];
                n_state = dtk_pkg::S_OUT;
                unique case (dtk_pkg::t_cmd'(r_item.command))
                    dtk_pkg::CMD_START: begin
                        n_last_time  = r_item.now_ms;
                        n_active     = 1'b1;
                        n_lo         = r_item.left_position;
                        n_ro         = r_item.right_position;
                        n_out.moving = 1'b1;
                    end
                    dtk_pkg::CMD_STOP: begin
                        n_active = 1'b0;
                    end
                    dtk_pkg::CMD_NONE: begin
                        n_out.moving = r_active;
                    end
                    dtk_pkg::CMD_POLL: begin
                        if (r_active && !s_early) begin
                            n_out.drive_update = 1'b1;
                            n_out.moving       = 1'b1;
                            if (s_ldone && s_rdone) begin
                                n_active     = 1'b0;
                                n_out.moving = 1'b0;
                            end else if (s_ldone) begin
                                n_out.right_drive = dir_mul(s_cfg.right_dir,
                                                            {s_boost[16], s_boost});
                            end else if (s_rdone) begin
                                n_out.left_drive = dir_mul(s_cfg.left_dir,
                                                           {s_boost[16], s_boost});
                            end else begin
                                n_out   = '0;
                                n_state = dtk_pkg::S_NUM;
                            end
                        end else begin
                            n_out.moving = r_active;
                        end
                    end
                    default: ;
                endcase
            end
            dtk_pkg::S_NUM: begin
                n_state = dtk_pkg::S_WAIT1;
            end
            dtk_pkg::S_WAIT1: begin
                if (s_div_rsp.done) begin
                    n_state = dtk_pkg::S_ERR;
                end
            end
            dtk_pkg::S_ERR: begin
                // expected right position minus measured, wrapped
                n_err   = s_div_rsp.quo + r_ro - r_item.right_position;
                n_state = dtk_pkg::S_PD;
            end
            dtk_pkg::S_PD: begin
                n_p     = s_p_full[15:0];
                n_n2    = s_n2_full[24:0];
                n_rep   = (r_err == r_last_err) ? (r_rep + 1'b1) : 16'd1;
                n_state = dtk_pkg::S_DEN;
            end
            dtk_pkg::S_DEN: begin
                // deadband of half the proportional gain
                n_den = s_den_full[31:0];
                if (!r_p[15] && (r_p != '0)) begin
                    n_p = r_p - s_half_kp;
                end else if (r_p[15]) begin
                    n_p = r_p + s_half_kp;
                end
                n_state = dtk_pkg::S_GO2;
            end
            dtk_pkg::S_GO2: begin
                n_state = dtk_pkg::S_WAIT2;
            end
            dtk_pkg::S_WAIT2: begin
                if (s_div_rsp.done) begin
                    n_state = dtk_pkg::S_MIX;
                end
            end
            dtk_pkg::S_MIX: begin
                n_g     = r_p + s_div_rsp.quo;
                n_state = dtk_pkg::S_DRV;
            end
            dtk_pkg::S_DRV: begin
                n_out.left_drive   = dir_mul(s_cfg.left_dir, s_lmag);
                n_out.right_drive  = dir_mul(s_cfg.right_dir, s_rmag);
                n_out.drive_update = 1'b1;
                n_out.moving       = 1'b1;
                n_last_err         = r_err;
                n_last_time        = r_item.now_ms;
                n_state            = dtk_pkg::S_OUT;
            end
            dtk_pkg::S_OUT: begin
                if (!i_out_stall) begin
                    n_state = dtk_pkg::S_IDLE;
                end
            end
            default: n_state = dtk_pkg::S_IDLE;
        endcase
    end

    // control and move state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtk_pkg::S_IDLE;
            r_active    <= 1'b0;
            r_last_time <= '0;
            r_last_err  <= '0;
            r_rep       <= '0;
            r_lo        <= '0;
            r_ro        <= '0;
        end else begin
            r_state     <= n_state;
            r_active    <= n_active;
            r_last_time <= n_last_time;
            r_last_err  <= n_last_err;
            r_rep       <= n_rep;
            r_lo        <= n_lo;
            r_ro        <= n_ro;
        end
    end

    // payload and work registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_dt   <= n_dt;
        r_prod <= n_prod;
        r_err  <= n_err;
        r_p    <= n_p;
        r_n2   <= n_n2;
        r_den  <= n_den;
        r_g    <= n_g;
        r_out  <= n_out;
    end

    assign o_in_stall  = (r_state != dtk_pkg::S_IDLE);
    assign o_out_valid = (r_state == dtk_pkg::S_OUT);
    assign o_out_item  = r_out;

    // never ready for an item while a result item is shown
    a_ready_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("input ready while result pending");

    // reported moving flag agrees with the move state
    a_moving_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.moving == r_active))
        else $error("moving flag disagrees with move state");

    // drives are zero when no update is reported
    a_quiet_drives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.drive_update |->
            (o_out_item.left_drive == '0) && (o_out_item.right_drive == '0))
        else $error("drive set without update");

endmodule

### bench/dtk_drive_checker.sv
`timescale 1ns / 100ps
// dtk_drive_checker: watches the item channels and the config port of the tracker core,
// keeps its own copy of the move state and registers, predicts and compares each result
// depends on dtk_pkg
module dtk_drive_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dtk_pkg::t_in_item          i_in_item,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  dtk_pkg::t_out_item         i_out_item,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic                       i_cfg_we,
    input  logic [dtk_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [dtk_pkg::CFG_DW-1:0] i_cfg_data,
    output int                         o_fail_count,
    output int                         o_pending
);

    // register copy and move state
    dtk_pkg::t_cfg      cfg;
    logic               move_on;
    logic        [31:0] last_ms;
    logic signed [15:0] prev_err;
    logic        [15:0] err_repeats;
    logic signed [15:0] left_org;
    logic signed [15:0] right_org;

    dtk_pkg::t_out_item pending_drives[$];
    int                 fails = 0;

    function automatic longint wrap16(input longint v);
        logic signed [15:0] t;
        t = v[15:0];
        return t;
    endfunction

    function automatic longint wrap32(input longint v);
        logic signed [31:0] t;
        t = v[31:0];
        return t;
    endfunction

    // one command through the tracker: updates the state copy, returns the drives
    task automatic step_tracker(input dtk_pkg::t_in_item it, output dtk_pkg::t_out_item res);
        longint      lpos, rpos, lo, ro, dt, la, ra, cs, kp, kd, ld, rd, pe, boost;
        longint      quo, aim, err, p, d, g, a, b, den;
        logic [31:0] elapsed;
        logic        ldone, rdone;
        lpos    = it.left_position;
        rpos    = it.right_position;
        lo      = left_org;
        ro      = right_org;
        pe      = prev_err;
        la      = cfg.left_amount;
        ra      = cfg.right_amount;
        cs      = cfg.base_speed;
        kp      = cfg.prop_gain;
        kd      = cfg.deriv_gain;
        ld      = cfg.left_dir;
        rd      = cfg.right_dir;
        boost   = dtk_pkg::FINISH_BOOST;
        elapsed = it.now_ms - last_ms;
        dt      = $signed(elapsed);
        res     = '0;
        case (dtk_pkg::t_cmd'(it.command))
            dtk_pkg::CMD_START: begin
                last_ms     = it.now_ms;
                move_on     = 1'b1;
                left_org    = it.left_position;
                right_org   = it.right_position;
                res.moving  = 1'b1;
            end
            dtk_pkg::CMD_STOP: begin
                move_on = 1'b0;
            end
            dtk_pkg::CMD_NONE: begin
                res.moving = move_on;
            end
            dtk_pkg::CMD_POLL: begin
                res.moving = move_on;
                if (move_on && dt >= longint'(cfg.poll_period)) begin
                    // distance ratio: where the right wheel should be by now
                    quo   = (la == 0) ? 0 : ((lpos - lo) * ra + la / 2) / la;
                    aim   = wrap16(quo + ro);
                    err   = wrap16(aim - rpos);
                    ldone = (lpos >= lo + la);
                    rdone = (rpos >= ro + ra);
                    res.drive_update = 1'b1;
                    if (ldone && rdone) begin
                        move_on    = 1'b0;
                        res.moving = 1'b0;
                    end else if (ldone) begin
                        res.right_drive = 16'(rd * (cs + boost));
                    end else if (rdone) begin
                        res.left_drive = 16'(ld * (cs + boost));
                    end else begin
                        // pd correction with deadband of half the proportional gain
                        p = wrap16(kp * err);
                        if (p > 0) begin
                            p = wrap16(p - kp / 2);
                        end else if (p < 0) begin
                            p = wrap16(p + kp / 2);
                        end
                        err_repeats = (err == pe) ? err_repeats + 16'd1 : 16'd1;
                        den = wrap32(dt * longint'(err_repeats));
                        d   = (den == 0) ? 0 : wrap16((kd * (err - pe)) / den);
                        g   = wrap16(p + d);
                        a   = cs - g;
                        b   = cs + g;
                        res.left_drive  = 16'(ld * ((a > cs) ? a : cs));
                        res.right_drive = 16'(rd * ((b > cs) ? b : cs));
                        prev_err = 16'(err);
                        last_ms  = it.now_ms;
                    end
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic signed [31:0] want,
                               input logic signed [31:0] got);
        if (want !== got) begin
            $error("%s expected %0d got %0d", name, want, got);
            fails++;
        end
    endtask

    // track config writes, predict on accepted commands, compare on accepted results
    always @(posedge i_clk) begin : watch
        dtk_pkg::t_out_item want;
        if (!i_rst_n) begin
            cfg.left_dir     = 2'sd1;
            cfg.right_dir    = 2'sd1;
            cfg.left_amount  = 15'd1;
            cfg.right_amount = 15'd0;
            cfg.base_speed   = 15'd0;
            cfg.prop_gain    = 8'd1;
            cfg.deriv_gain   = 8'd0;
            cfg.poll_period  = 16'd10;
            move_on     = 1'b0;
            last_ms     = '0;
            prev_err    = '0;
            err_repeats = '0;
            left_org    = '0;
            right_org   = '0;
            pending_drives.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_drives.size() == 0) begin
                    $error("result item with no command waiting for it");
                    fails++;
                end else begin
                    want = pending_drives.pop_front();
                    check_field("left_drive", want.left_drive, i_out_item.left_drive);
                    check_field("right_drive", want.right_drive, i_out_item.right_drive);
                    check_field("drive_update", want.drive_update, i_out_item.drive_update);
                    check_field("moving", want.moving, i_out_item.moving);
                end
            end
            if (i_cfg_we) begin
                case (dtk_pkg::t_cfg_idx'(i_cfg_idx))
                    dtk_pkg::REG_LEFT_DIR:     cfg.left_dir     = i_cfg_data[1:0];
                    dtk_pkg::REG_RIGHT_DIR:    cfg.right_dir    = i_cfg_data[1:0];
                    dtk_pkg::REG_LEFT_AMOUNT:  cfg.left_amount  = i_cfg_data[14:0];
                    dtk_pkg::REG_RIGHT_AMOUNT: cfg.right_amount = i_cfg_data[14:0];
                    dtk_pkg::REG_BASE_SPEED:   cfg.base_speed   = i_cfg_data[14:0];
                    dtk_pkg::REG_PROP_GAIN:    cfg.prop_gain    = i_cfg_data[7:0];
                    dtk_pkg::REG_DERIV_GAIN:   cfg.deriv_gain   = i_cfg_data[7:0];
                    dtk_pkg::REG_POLL_PERIOD:  cfg.poll_period  = i_cfg_data[15:0];
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                step_tracker(i_in_item, want);
                pending_drives.push_back(want);
            end
        end
        o_pending    = pending_drives.size();
        o_fail_count = fails;
    end

endmodule

### bench/differential_drive_pd_tracker_core_test.sv
`timescale 1ns / 100ps
// differential_drive_pd_tracker_core_test: stimulus, flow control and verdict for the core
// instantiates the core and dtk_drive_checker; depends on dtk_pkg
module differential_drive_pd_tracker_core_test;

    // slowest correct gap between handshakes is a pd poll plus both sides'
    // draws, or the long receiver hold; several times that over
    localparam int QUIET_LIMIT     = 3000;
    localparam int LONG_HOLD       = 200;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 125;

    logic                       clk;
    logic                       rst_n;
    dtk_pkg::t_in_item          in_item;
    logic                       in_valid;
    logic                       in_stall;
    dtk_pkg::t_out_item         out_item;
    logic                       out_valid;
    logic                       out_stall;
    logic                       cfg_we;
    logic [dtk_pkg::CFG_AW-1:0] cfg_idx;
    logic [dtk_pkg::CFG_DW-1:0] cfg_data;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    bit no_gaps      = 1'b0;
    bit long_hold    = 1'b0;
    int la_now       = 1;
    int ra_now       = 0;
    int pp_now       = 10;

    differential_drive_pd_tracker_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_item  (in_item),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .o_out_item (out_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    dtk_drive_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_item   (in_item),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_out_item  (out_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    // 10 ns clock
    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // watchdog on handshake activity
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random hold-off per item, one long hold on request
    initial begin : drain_results
        int w;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (long_hold) begin
                w         = LONG_HOLD;
                long_hold = 1'b0;
            end else begin
                w = no_gaps ? 0 : $urandom_range(0, 9);
            end
            if (w > 0) begin
                out_stall = 1'b1;
                repeat (w) @(negedge clk);
            end
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // offer one command item after a random gap, return at the accepting edge
    task automatic send(input dtk_pkg::t_cmd c, input logic [15:0] lp, input logic [15:0] rp,
                        input logic [31:0] t);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        @(negedge clk);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item.command        = c;
        in_item.left_position  = lp;
        in_item.right_position = rp;
        in_item.now_ms         = t;
        in_valid               = 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    // wait until every result item has come back
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // register write with random bits above the register width
    task automatic write_reg(input dtk_pkg::t_cfg_idx idx, input int value, input int w);
        int keep;
        keep = (1 << w) - 1;
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = 16'(($urandom & ~keep) | (value & keep));
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    task automatic load_setting(input int ld, input int rd, input int la, input int ra,
                                input int cs, input int kp, input int kd, input int pp);
        write_reg(dtk_pkg::REG_LEFT_DIR, ld, 2);
        write_reg(dtk_pkg::REG_RIGHT_DIR, rd, 2);
        write_reg(dtk_pkg::REG_LEFT_AMOUNT, la, 15);
        write_reg(dtk_pkg::REG_RIGHT_AMOUNT, ra, 15);
        write_reg(dtk_pkg::REG_BASE_SPEED, cs, 15);
        write_reg(dtk_pkg::REG_PROP_GAIN, kp, 8);
        write_reg(dtk_pkg::REG_DERIV_GAIN, kd, 8);
        write_reg(dtk_pkg::REG_POLL_PERIOD, pp, 16);
        la_now = la;
        ra_now = ra;
        pp_now = pp;
    endtask

    initial begin : stimulus
        int            ph;
        int            sent;
        int            kind;
        int            polls;
        dtk_pkg::t_cmd c;
        logic [15:0]   lp;
        logic [15:0]   rp;
        logic [31:0]   t;

        rst_n    = 1'b0;
        in_item  = '0;
        in_valid = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // directed, register defaults: idle poll, ignored command, stop, a short move
        send(dtk_pkg::CMD_POLL, 16'h8000, 16'h7fff, 32'hffff_ffff);
        send(dtk_pkg::CMD_NONE, 16'h0000, 16'h0000, 32'h0000_0000);
        send(dtk_pkg::CMD_STOP, 16'h1234, 16'h4321, 32'h0000_0001);
        send(dtk_pkg::CMD_START, 16'd0, 16'd0, 32'd100);
        send(dtk_pkg::CMD_POLL, 16'd0, 16'd0, 32'd105);
        send(dtk_pkg::CMD_POLL, -16'sd5, -16'sd5, 32'd110);
        send(dtk_pkg::CMD_POLL, -16'sd5, -16'sd5, 32'd120);
        send(dtk_pkg::CMD_POLL, 16'd1, -16'sd3, 32'd130);
        send(dtk_pkg::CMD_POLL, -16'sd3, 16'd3, 32'd140);
        send(dtk_pkg::CMD_POLL, 16'd5, 16'd5, 32'd150);
        send(dtk_pkg::CMD_NONE, 16'd5, 16'd5, 32'd160);

        // directed, extremes: zero left amount, full gains and speed, zero period
        wait_idle();
        load_setting(-1, -2, 0, 32767, 32767, 255, 255, 0);
        send(dtk_pkg::CMD_START, 16'h8000, 16'h7fff, 32'h8000_0000);
        send(dtk_pkg::CMD_POLL, 16'h7fff, 16'h8000, 32'h7fff_ffff);
        send(dtk_pkg::CMD_POLL, 16'h7fff, 16'h8000, 32'h8000_0000);
        send(dtk_pkg::CMD_START, 16'd0, 16'd0, 32'd0);
        send(dtk_pkg::CMD_POLL, -16'sd1, -16'sd100, 32'd0);
        send(dtk_pkg::CMD_POLL, -16'sd2, 16'h8000, 32'd5);
        send(dtk_pkg::CMD_STOP, 16'd0, 16'd0, 32'd6);
        send(dtk_pkg::CMD_NONE, 16'hffff, 16'hffff, 32'hffff_ffff);

        // random phases, each under its own register setting
        for (ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: load_setting(1, -1, 1, 0, 0, 0, 0, 0);
                1: load_setting(-1, 1, 32767, 32767, 32767, 255, 255, 65535);
                default: load_setting($urandom_range(0, 3), $urandom_range(0, 3),
                                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767)
                                                                  : $urandom_range(1, 300),
                                      $urandom_range(0, 300),
                                      ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767)
                                                                  : $urandom_range(0, 2000),
                                      $urandom_range(0, 255), $urandom_range(0, 255),
                                      $urandom_range(0, 40));
            endcase
            if (ph == 2) begin
                long_hold = 1'b1;
            end
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                no_gaps = ((sent % 60) < 12);
                kind    = $urandom_range(0, 9);
                if (kind < 7) begin
                    // well-formed move: start, then polls that mostly advance both wheels
                    lp = ($urandom_range(0, 1) == 1) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 2000) - 1000);
                    rp = ($urandom_range(0, 1) == 1) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 2000) - 1000);
                    t  = $urandom;
                    send(dtk_pkg::CMD_START, lp, rp, t);
                    sent++;
                    polls = $urandom_range(2, 30);
                    repeat (polls) begin
                        if ($urandom_range(0, 3) != 0) begin
                            lp = lp + 16'($urandom_range(0, la_now / 10 + 1));
                            rp = rp + 16'($urandom_range(0, ra_now / 10 + 1))
                                    + 16'($urandom_range(0, 4)) - 16'd2;
                        end
                        if ($urandom_range(0, 4) == 0) begin
                            t = t + $urandom_range(0, pp_now);
                        end else begin
                            t = t + pp_now + $urandom_range(0, 20);
                        end
                        send(dtk_pkg::CMD_POLL, lp, rp, t);
                        sent++;
                    end
                    if ($urandom_range(0, 2) == 0) begin
                        send(dtk_pkg::CMD_STOP, 16'($urandom), 16'($urandom), $urandom);
                        sent++;
                    end
                end else if (kind == 7) begin
                    // noise: any command, any field
                    repeat ($urandom_range(1, 6)) begin
                        c = dtk_pkg::t_cmd'($urandom_range(0, 3));
                        send(c, 16'($urandom), 16'($urandom), $urandom);
                        if (c != dtk_pkg::CMD_NONE) begin
                            sent++;
                        end
                    end
                end else if (kind == 8) begin
                    // polls with no move running
                    send(dtk_pkg::CMD_STOP, 16'($urandom), 16'($urandom), $urandom);
                    sent++;
                    repeat ($urandom_range(1, 4)) begin
                        send(dtk_pkg::CMD_POLL, 16'($urandom), 16'($urandom), $urandom);
                        sent++;
                    end
                end else begin
                    // broken move: start, then polls with arbitrary positions and times
                    t = $urandom;
                    send(dtk_pkg::CMD_START, 16'($urandom), 16'($urandom), t);
                    sent++;
                    repeat ($urandom_range(1, 8)) begin
                        t = t + (($urandom_range(0, 1) == 1) ? $urandom
                                                             : $urandom_range(0, 100));
                        send(dtk_pkg::CMD_POLL, 16'($urandom), 16'($urandom), t);
                        sent++;
                    end
                end
            end
        end

        // let the last results drain, then give the verdict
        no_gaps = 1'b0;
        wait_idle();
        repeat (100) @(negedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
